FILE: rtl/core/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, masked while reset is high
`define SJGJ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that is also checked during reset
`define SJGJ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/sjgj_pkg.sv
`default_nettype none
package sjgj_pkg;

   localparam int ANGLE_FRAC_BITS = 12;
   localparam int OUT_FRAC_BITS   = 14;
   localparam int CORDIC_STEPS    = 16;

   localparam int ANG_W     = 16;
   localparam int OUT_W     = 18;
   localparam int COL_W     = 3;
   localparam int JOINTS    = 6;
   localparam int ROWS      = 3;
   localparam int LINK_W    = 3;
   localparam int WF        = 28;
   localparam int TF        = 30;
   localparam int GW        = 32;
   localparam int XW        = 34;
   localparam int PW        = 2 * GW;
   localparam int MW        = 2 * GW + 1;
   localparam int SW        = 2 * GW + 2;
   localparam int ANG_SHIFT = TF - ANGLE_FRAC_BITS;
   localparam int AW        = (ANG_W + ANG_SHIFT + 2 > 36) ? ANG_W + ANG_SHIFT + 2 : 36;
   localparam int SPC       = 2;
   localparam int STEP_W    = $clog2(CORDIC_STEPS + SPC + 1);
   localparam int ATAN_IW   = 5;
   localparam int OUT_SH    = WF - OUT_FRAC_BITS;

   typedef logic signed [GW-1:0]    geo_type;
   typedef logic signed [SW-1:0]    wide_type;
   typedef logic signed [OUT_W-1:0] out_type;

   typedef struct packed {
      logic              load;
      logic              mul;
      logic              upd;
      logic [LINK_W-1:0] joint;
   } chain_step_type;

   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(JOINTS - 1);
   localparam logic [LINK_W-1:0] TOOL_LINK = LINK_W'(JOINTS);

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic signed [AW-1:0] TWO_PI  = AW'(64'sd6746518852);
   localparam logic signed [AW-1:0] PI      = AW'(64'sd3373259426);
   localparam logic signed [AW-1:0] HALF_PI = AW'(64'sd1686629713);
   localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(64'sd652032874);

   localparam geo_type  ONE_GEO   = geo_type'(64'sd1 <<< WF);
   localparam wide_type RND_HALF  = wide_type'(1) <<< (WF - 1);
   localparam logic signed [GW:0] OUT_MAX = (GW+1)'(2 ** (OUT_W - 1) - 1);
   localparam logic signed [GW:0] OUT_MIN = (GW+1)'(-(2 ** (OUT_W - 1)));
   localparam logic signed [GW:0] OUT_HALF = (GW+1)'(1 <<< (OUT_SH - 1));

   localparam geo_type BASE_OFF [ROWS] = '{-32'sd7247757, 32'sd29527900, 32'sd135559905};

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   function automatic logic signed [AW-1:0] atan_q30(input logic [ATAN_IW-1:0] i);
      return AW'({1'b0, ATAN_TAB[i]});
   endfunction

   function automatic logic [1:0] joint_axis(input logic [LINK_W-1:0] k);
      logic [1:0] a;
      case (k)
         3'd0:    a = AXIS_Y;
         3'd1:    a = AXIS_X;
         3'd2:    a = AXIS_Z;
         3'd3:    a = AXIS_Y;
         3'd4:    a = AXIS_Y;
         3'd5:    a = AXIS_X;
         default: a = AXIS_X;
      endcase
      return a;
   endfunction

   function automatic logic [1:0] next_axis(input logic [1:0] a);
      logic [1:0] n;
      case (a)
         AXIS_X:  n = AXIS_Y;
         AXIS_Y:  n = AXIS_Z;
         default: n = AXIS_X;
      endcase
      return n;
   endfunction

   // offset applied before each joint turns; the last entry is the tool
   function automatic geo_type link_off(input logic [LINK_W-1:0] k, input logic [1:0] c);
      geo_type o;
      o = '0;
      case (k)
         3'd1: begin
            case (c)
               AXIS_X:  o = 32'sd1073742;
               AXIS_Y:  o = 32'sd29259465;
               default: o = -32'sd10737418;
            endcase
         end
         3'd2: begin
            case (c)
               AXIS_X:  o = '0;
               AXIS_Y:  o = 32'sd150324;
               default: o = -32'sd18790482;
            endcase
         end
         3'd3: begin
            case (c)
               AXIS_X:  o = '0;
               AXIS_Y:  o = 32'sd391916;
               default: o = -32'sd50465866;
            endcase
         end
         3'd4: begin
            case (c)
               AXIS_X:  o = '0;
               AXIS_Y:  o = 32'sd1879048;
               default: o = -32'sd59861107;
            endcase
         end
         3'd6: begin
            case (c)
               AXIS_X:  o = '0;
               AXIS_Y:  o = '0;
               default: o = -32'sd53687091;
            endcase
         end
         default: o = '0;
      endcase
      return o;
   endfunction

   function automatic geo_type rnd_geo(input wide_type v);
      wide_type t;
      t = (v + RND_HALF) >>> WF;
      return t[GW-1:0];
   endfunction

   function automatic out_type enc_out(input geo_type v);
      logic signed [GW:0] t;
      out_type            r;
      t = ((GW+1)'(v) + OUT_HALF) >>> OUT_SH;
      if (t > OUT_MAX) begin
         t = OUT_MAX;
      end else if (t < OUT_MIN) begin
         t = OUT_MIN;
      end
      r = t[OUT_W-1:0];
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sjgj_channels.sv
`default_nettype none
interface sjgj_req_if;
   import sjgj_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [ANG_W-1:0] joint1_angle;
   logic signed [ANG_W-1:0] joint2_angle;
   logic signed [ANG_W-1:0] joint3_angle;
   logic signed [ANG_W-1:0] joint4_angle;
   logic signed [ANG_W-1:0] joint5_angle;
   logic signed [ANG_W-1:0] joint6_angle;

   modport source (output valid, joint1_angle, joint2_angle, joint3_angle,
                   joint4_angle, joint5_angle, joint6_angle, input ready);
   modport sink (input valid, joint1_angle, joint2_angle, joint3_angle,
                 joint4_angle, joint5_angle, joint6_angle, output ready);
endinterface

interface sjgj_rsp_if;
   import sjgj_pkg::*;
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] column_index;
   out_type          linear_x;
   out_type          linear_y;
   out_type          linear_z;
   out_type          axis_x;
   out_type          axis_y;
   out_type          axis_z;
   out_type          tip_x;
   out_type          tip_y;
   out_type          tip_z;
   logic             last_column;

   modport source (output valid, column_index, linear_x, linear_y, linear_z,
                   axis_x, axis_y, axis_z, tip_x, tip_y, tip_z, last_column,
                   input ready);
   modport sink (input valid, column_index, linear_x, linear_y, linear_z,
                 axis_x, axis_y, axis_z, tip_x, tip_y, tip_z, last_column,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sjgj_cordic_lane.sv
`default_nettype none
module sjgj_cordic_lane (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic                            take,
   input  logic signed [sjgj_pkg::ANG_W-1:0] angle,
   output logic                            idle,
   output logic                            done,
   output sjgj_pkg::geo_type               sn,
   output sjgj_pkg::geo_type               cs
);
   import sjgj_pkg::*;

   typedef enum logic [2:0] {L_IDLE, L_WRAP, L_PIW, L_FOLD, L_ROT, L_DONE} lane_state_type;

   lane_state_type          state_ff, state_in;
   logic signed [AW-1:0]    a_ff, a_in;
   logic signed [XW-1:0]    x_ff, x_in, y_ff, y_in;
   logic                    flip_ff, flip_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic signed [XW-1:0]    xs, ys, xr, yr;

   always_comb begin
      logic signed [AW-1:0]  at;
      logic signed [XW-1:0]  xt, yt, tt;
      logic [ATAN_IW-1:0]    i;
      state_in = state_ff;
      a_in     = a_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      flip_in  = flip_ff;
      step_in  = step_ff;
      at       = a_ff;
      xt       = x_ff;
      yt       = y_ff;
      tt       = '0;
      i        = '0;
      case (state_ff)
         L_IDLE: begin
            if (load) begin
               a_in     = AW'(angle) <<< ANG_SHIFT;
               state_in = L_WRAP;
            end
         end
         L_WRAP: begin
            if (a_ff >= TWO_PI) begin
               a_in = a_ff - TWO_PI;
            end else if (a_ff <= -TWO_PI) begin
               a_in = a_ff + TWO_PI;
            end else begin
               state_in = L_PIW;
            end
         end
         L_PIW: begin
            if (a_ff > PI) begin
               a_in = a_ff - TWO_PI;
            end else if (a_ff < -PI) begin
               a_in = a_ff + TWO_PI;
            end
            state_in = L_FOLD;
         end
         L_FOLD: begin
            flip_in = 1'b0;
            if (a_ff > HALF_PI) begin
               a_in    = a_ff - PI;
               flip_in = 1'b1;
            end else if (a_ff < -HALF_PI) begin
               a_in    = a_ff + PI;
               flip_in = 1'b1;
            end
            x_in     = CORDIC_GAIN;
            y_in     = '0;
            step_in  = '0;
            state_in = L_ROT;
         end
         L_ROT: begin
            for (int j = 0; j < SPC; j++) begin
               i = ATAN_IW'(step_ff) + ATAN_IW'(j);
               if (int'(step_ff) + j < CORDIC_STEPS) begin
                  if (!at[AW-1]) begin
                     tt = xt - (yt >>> i);
                     yt = yt + (xt >>> i);
                     at = at - atan_q30(i);
                  end else begin
                     tt = xt + (yt >>> i);
                     yt = yt - (xt >>> i);
                     at = at + atan_q30(i);
                  end
                  xt = tt;
               end
            end
            x_in    = xt;
            y_in    = yt;
            a_in    = at;
            step_in = step_ff + STEP_W'(SPC);
            if (int'(step_ff) + SPC >= CORDIC_STEPS) begin
               state_in = L_DONE;
            end
         end
         L_DONE: begin
            if (take) begin
               state_in = L_IDLE;
            end
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff    <= a_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      flip_ff <= flip_in;
      step_ff <= step_in;
   end

   assign xs = flip_ff ? -x_ff : x_ff;
   assign ys = flip_ff ? -y_ff : y_ff;
   assign xr = (xs + XW'(1 <<< (TF - WF - 1))) >>> (TF - WF);
   assign yr = (ys + XW'(1 <<< (TF - WF - 1))) >>> (TF - WF);
   assign cs = xr[GW-1:0];
   assign sn = yr[GW-1:0];
   assign idle = (state_ff == L_IDLE);
   assign done = (state_ff == L_DONE);

endmodule
`default_nettype wire

FILE: rtl/core/sjgj_row_lane.sv
`default_nettype none
module sjgj_row_lane (
   input  logic                     clock,
   input  sjgj_pkg::chain_step_type ctl,
   input  logic [1:0]               row,
   input  sjgj_pkg::geo_type        sn,
   input  sjgj_pkg::geo_type        cs,
   output sjgj_pkg::geo_type        ax_out  [sjgj_pkg::JOINTS],
   output sjgj_pkg::geo_type        org_out [sjgj_pkg::JOINTS],
   output sjgj_pkg::geo_type        tip_out
);
   import sjgj_pkg::*;

   geo_type               r_ff   [ROWS];
   geo_type               r_in   [ROWS];
   geo_type               p_ff, p_in;
   logic signed [PW-1:0]  pp_ff  [ROWS];
   logic signed [PW-1:0]  pp_in  [ROWS];
   logic signed [PW-1:0]  pr_ff  [4];
   logic signed [PW-1:0]  pr_in  [4];
   geo_type               ax_ff  [JOINTS];
   geo_type               ax_in  [JOINTS];
   geo_type               org_ff [JOINTS];
   geo_type               org_in [JOINTS];

   always_comb begin
      logic [1:0] a, u, v;
      geo_type    p_new;
      a      = joint_axis(ctl.joint);
      u      = next_axis(a);
      v      = next_axis(u);
      r_in   = r_ff;
      p_in   = p_ff;
      pp_in  = pp_ff;
      pr_in  = pr_ff;
      ax_in  = ax_ff;
      org_in = org_ff;
      p_new  = p_ff;
      if (ctl.load) begin
         for (int c = 0; c < ROWS; c++) begin
            r_in[c] = (c == int'(row)) ? ONE_GEO : '0;
         end
         p_in = BASE_OFF[row];
      end
      if (ctl.mul) begin
         for (int c = 0; c < ROWS; c++) begin
            pp_in[c] = r_ff[c] * link_off(ctl.joint, 2'(c));
         end
         pr_in[0] = cs * r_ff[u];
         pr_in[1] = sn * r_ff[v];
         pr_in[2] = cs * r_ff[v];
         pr_in[3] = sn * r_ff[u];
      end
      if (ctl.upd) begin
         p_new = p_ff + rnd_geo(SW'(pp_ff[0]) + SW'(pp_ff[1]) + SW'(pp_ff[2]));
         p_in  = p_new;
         if (ctl.joint != TOOL_LINK) begin
            r_in[u]            = rnd_geo(SW'(pr_ff[0]) + SW'(pr_ff[1]));
            r_in[v]            = rnd_geo(SW'(pr_ff[2]) - SW'(pr_ff[3]));
            ax_in[ctl.joint]   = r_ff[a];
            org_in[ctl.joint]  = p_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      p_ff   <= p_in;
      pp_ff  <= pp_in;
      pr_ff  <= pr_in;
      ax_ff  <= ax_in;
      org_ff <= org_in;
   end

   assign ax_out  = ax_ff;
   assign org_out = org_ff;
   assign tip_out = p_ff;

endmodule
`default_nettype wire

FILE: rtl/core/sjgj_column_merge.sv
`default_nettype none
module sjgj_column_merge (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   output logic              busy,
   input  sjgj_pkg::geo_type ax_in  [sjgj_pkg::ROWS][sjgj_pkg::JOINTS],
   input  sjgj_pkg::geo_type org_in [sjgj_pkg::ROWS][sjgj_pkg::JOINTS],
   input  sjgj_pkg::geo_type tip_in [sjgj_pkg::ROWS],
   sjgj_rsp_if.source        rsp
);
   import sjgj_pkg::*;

   logic                  active_ff, active_in;
   logic [COL_W-1:0]      issue_ff, issue_in;
   geo_type               ax_ff  [ROWS][JOINTS];
   geo_type               axs_in [ROWS][JOINTS];
   logic signed [GW:0]    d_ff   [ROWS][JOINTS];
   logic signed [GW:0]    d_in   [ROWS][JOINTS];
   geo_type               tip_ff [ROWS];
   geo_type               tip_in_d [ROWS];

   logic                  pv_ff, pv_in;
   logic signed [MW-1:0]  m_ff [6];
   logic signed [MW-1:0]  m_in [6];
   geo_type               pax_ff [ROWS];
   geo_type               pax_in [ROWS];
   geo_type               ptip_ff [ROWS];
   geo_type               ptip_in [ROWS];
   logic [COL_W-1:0]      pidx_ff, pidx_in;

   logic                  ov_ff, ov_in;
   logic [COL_W-1:0]      oidx_ff, oidx_in;
   out_type               olin_ff [ROWS];
   out_type               olin_in [ROWS];
   out_type               oax_ff [ROWS];
   out_type               oax_in [ROWS];
   out_type               otip_ff [ROWS];
   out_type               otip_in [ROWS];
   logic                  olast_ff, olast_in;

   logic                  out_load, prod_load;

   assign out_load  = pv_ff && (!ov_ff || rsp.ready);
   assign prod_load = active_ff && (!pv_ff || out_load);

   always_comb begin
      logic [COL_W-1:0] k;
      k         = issue_ff;
      active_in = active_ff;
      issue_in  = issue_ff;
      axs_in    = ax_ff;
      d_in      = d_ff;
      tip_in_d  = tip_ff;
      pv_in     = pv_ff;
      m_in      = m_ff;
      pax_in    = pax_ff;
      ptip_in   = ptip_ff;
      pidx_in   = pidx_ff;
      ov_in     = ov_ff;
      oidx_in   = oidx_ff;
      olin_in   = olin_ff;
      oax_in    = oax_ff;
      otip_in   = otip_ff;
      olast_in  = olast_ff;
      if (load) begin
         active_in = 1'b1;
         issue_in  = '0;
         axs_in    = ax_in;
         tip_in_d  = tip_in;
         for (int r = 0; r < ROWS; r++) begin
            for (int j = 0; j < JOINTS; j++) begin
               d_in[r][j] = (GW+1)'(tip_in[r]) - (GW+1)'(org_in[r][j]);
            end
         end
      end
      if (prod_load) begin
         m_in[0] = ax_ff[1][k] * d_ff[2][k];
         m_in[1] = ax_ff[2][k] * d_ff[1][k];
         m_in[2] = ax_ff[2][k] * d_ff[0][k];
         m_in[3] = ax_ff[0][k] * d_ff[2][k];
         m_in[4] = ax_ff[0][k] * d_ff[1][k];
         m_in[5] = ax_ff[1][k] * d_ff[0][k];
         for (int r = 0; r < ROWS; r++) begin
            pax_in[r]  = ax_ff[r][k];
            ptip_in[r] = tip_ff[r];
         end
         pidx_in  = k;
         issue_in = k + COL_W'(1);
         if (k == LAST_COL) begin
            active_in = 1'b0;
         end
      end
      if (prod_load) begin
         pv_in = 1'b1;
      end else if (out_load) begin
         pv_in = 1'b0;
      end
      if (out_load) begin
         for (int r = 0; r < ROWS; r++) begin
            olin_in[r] = enc_out(rnd_geo(SW'(m_ff[2*r]) - SW'(m_ff[2*r+1])));
            oax_in[r]  = enc_out(pax_ff[r]);
            otip_in[r] = enc_out(ptip_ff[r]);
         end
         oidx_in  = pidx_ff;
         olast_in = (pidx_ff == LAST_COL);
         ov_in    = 1'b1;
      end else if (rsp.ready) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pv_ff     <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         active_ff <= active_in;
         pv_ff     <= pv_in;
         ov_ff     <= ov_in;
      end
      issue_ff <= issue_in;
      ax_ff    <= axs_in;
      d_ff     <= d_in;
      tip_ff   <= tip_in_d;
      m_ff     <= m_in;
      pax_ff   <= pax_in;
      ptip_ff  <= ptip_in;
      pidx_ff  <= pidx_in;
      oidx_ff  <= oidx_in;
      olin_ff  <= olin_in;
      oax_ff   <= oax_in;
      otip_ff  <= otip_in;
      olast_ff <= olast_in;
   end

   assign busy             = active_ff;
   assign rsp.valid        = ov_ff;
   assign rsp.column_index = oidx_ff;
   assign rsp.linear_x     = olin_ff[0];
   assign rsp.linear_y     = olin_ff[1];
   assign rsp.linear_z     = olin_ff[2];
   assign rsp.axis_x       = oax_ff[0];
   assign rsp.axis_y       = oax_ff[1];
   assign rsp.axis_z       = oax_ff[2];
   assign rsp.tip_x        = otip_ff[0];
   assign rsp.tip_y        = otip_ff[1];
   assign rsp.tip_z        = otip_ff[2];
   assign rsp.last_column  = olast_ff;

endmodule
`default_nettype wire

FILE: rtl/core/six_joint_geometric_jacobian.sv
`default_nettype none
// Geometric Jacobian of a fixed six-joint arm. Each request carries six joint angles and gives
// six responses, one Jacobian column per joint in order, the sixth marked last, each with the
// tool tip position. Six CORDIC lanes take the sine and cosine of all joints at once, two
// rotation steps a cycle, after bringing each angle into range a full turn at a time;
// three row lanes then chain the six joint frames and the tool offset, each link in a multiply
// state and an update state, and the column stage sends one column a cycle while the response
// is not stalled. The three parts overlap across requests, so one request's chain can run
// while the columns of the one before are sent and the lanes work on the next request.
module six_joint_geometric_jacobian (
   input  logic       clock,
   input  logic       reset,
   sjgj_req_if.sink   req,
   sjgj_rsp_if.source rsp
);
   import sjgj_pkg::*;

   typedef enum logic [1:0] {CH_IDLE, CH_MUL, CH_UPD} chain_state_type;

   logic signed [ANG_W-1:0] angle [JOINTS];
   logic [JOINTS-1:0]       lane_idle, lane_done;
   geo_type                 lane_sn [JOINTS];
   geo_type                 lane_cs [JOINTS];
   geo_type                 sn_ff   [JOINTS];
   geo_type                 cs_ff   [JOINTS];

   chain_state_type         ch_state_ff, ch_state_in;
   logic [LINK_W-1:0]       joint_ff, joint_in;
   logic                    full_ff, full_in;
   logic                    req_fire, chain_start, merge_load, merge_busy;
   logic [LINK_W-1:0]       jsel;
   chain_step_type          ctl;

   geo_type                 ax_row  [ROWS][JOINTS];
   geo_type                 org_row [ROWS][JOINTS];
   geo_type                 tip_row [ROWS];

   assign angle[0] = req.joint1_angle;
   assign angle[1] = req.joint2_angle;
   assign angle[2] = req.joint3_angle;
   assign angle[3] = req.joint4_angle;
   assign angle[4] = req.joint5_angle;
   assign angle[5] = req.joint6_angle;

   assign req.ready   = &lane_idle;
   assign req_fire    = req.valid && (&lane_idle);
   assign chain_start = (&lane_done) && (ch_state_ff == CH_IDLE) && !full_ff;
   assign merge_load  = full_ff && !merge_busy;

   for (genvar g = 0; g < JOINTS; g++) begin : g_lane
      sjgj_cordic_lane u_lane (
         .clock (clock),
         .reset (reset),
         .load  (req_fire),
         .take  (chain_start),
         .angle (angle[g]),
         .idle  (lane_idle[g]),
         .done  (lane_done[g]),
         .sn    (lane_sn[g]),
         .cs    (lane_cs[g])
      );
   end

   always_comb begin
      ch_state_in = ch_state_ff;
      joint_in    = joint_ff;
      full_in     = full_ff;
      case (ch_state_ff)
         CH_IDLE: begin
            if (chain_start) begin
               ch_state_in = CH_MUL;
               joint_in    = '0;
            end
         end
         CH_MUL: ch_state_in = CH_UPD;
         CH_UPD: begin
            if (joint_ff == TOOL_LINK) begin
               ch_state_in = CH_IDLE;
               full_in     = 1'b1;
            end else begin
               joint_in    = joint_ff + LINK_W'(1);
               ch_state_in = CH_MUL;
            end
         end
         default: ch_state_in = CH_IDLE;
      endcase
      if (merge_load) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_state_ff <= CH_IDLE;
         full_ff     <= 1'b0;
      end else begin
         ch_state_ff <= ch_state_in;
         full_ff     <= full_in;
      end
      joint_ff <= joint_in;
      if (chain_start) begin
         sn_ff <= lane_sn;
         cs_ff <= lane_cs;
      end
   end

   assign ctl.load  = chain_start;
   assign ctl.mul   = (ch_state_ff == CH_MUL);
   assign ctl.upd   = (ch_state_ff == CH_UPD);
   assign ctl.joint = joint_ff;
   assign jsel      = (joint_ff < TOOL_LINK) ? joint_ff : '0;

   for (genvar r = 0; r < ROWS; r++) begin : g_row
      sjgj_row_lane u_row (
         .clock   (clock),
         .ctl     (ctl),
         .row     (2'(r)),
         .sn      (sn_ff[jsel]),
         .cs      (cs_ff[jsel]),
         .ax_out  (ax_row[r]),
         .org_out (org_row[r]),
         .tip_out (tip_row[r])
      );
   end

   sjgj_column_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .load   (merge_load),
      .busy   (merge_busy),
      .ax_in  (ax_row),
      .org_in (org_row),
      .tip_in (tip_row),
      .rsp    (rsp)
   );

endmodule
`default_nettype wire

FILE: rtl/core/sjgj_checker.sv
`default_nettype none
`include "assert_macros.svh"
module sjgj_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sjgj_pkg::COL_W-1:0]    rsp_column_index,
   input logic                          rsp_last_column
);
   import sjgj_pkg::*;

   `SJGJ_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_column_index), "stalled response changed")
   `SJGJ_ASSERT(a_last_flag, clock, reset, rsp_valid |-> (rsp_last_column == (rsp_column_index == LAST_COL)), "last flag not on final column")
   `SJGJ_ASSERT(a_col_range, clock, reset, rsp_valid |-> (rsp_column_index <= LAST_COL), "column index out of range")
   `SJGJ_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind six_joint_geometric_jacobian sjgj_checker u_sjgj_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_column_index (rsp.column_index),
   .rsp_last_column  (rsp.last_column)
);
`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sjgj_pkg::*;

   typedef struct packed {
      logic [COL_W-1:0] column_index;
      out_type          linear_x;
      out_type          linear_y;
      out_type          linear_z;
      out_type          axis_x;
      out_type          axis_y;
      out_type          axis_z;
      out_type          tip_x;
      out_type          tip_y;
      out_type          tip_z;
      logic             last_column;
   } column_type;

   typedef logic signed [ANG_W-1:0] angle_type;
   typedef angle_type angles_type [JOINTS];

   localparam longint GAIN_Q = 64'sd652032874;
   localparam longint PI_Q = 64'sd3373259426;
   localparam longint HALF_PI_Q = 64'sd1686629713;
   localparam longint TWO_PI_Q = 64'sd6746518852;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam longint ATAN_Q [32] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
      'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
      'h00000001, 'h00000000
   };
   localparam int JOINT_AXIS [JOINTS] = '{1, 0, 2, 1, 1, 0};
   localparam longint BASE_Q [3] = '{-7247757, 29527900, 135559905};
   localparam longint LINK_Q [JOINTS][3] = '{
      '{0, 0, 0}, '{1073742, 29259465, -10737418}, '{0, 150324, -18790482},
      '{0, 391916, -50465866}, '{0, 1879048, -59861107}, '{0, 0, 0}
   };
   localparam longint TOOL_Q [3] = '{0, 0, -53687091};

   logic clock;
   logic reset;
   sjgj_req_if req ();
   sjgj_rsp_if rsp ();

   six_joint_geometric_jacobian dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   column_type expected_columns [$];
   int      errors;
   int      requests_sent;
   int      columns_seen;
   int      idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint round_shift(longint v, int s);
      if (s == 0) begin
         return v;
      end
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic out_type to_output(longint v);
      longint r;
      r = round_shift(v, WF - OUT_FRAC_BITS);
      if (r > 131071) begin
         r = 131071;
      end else if (r < -131072) begin
         r = -131072;
      end
      return out_type'(r);
   endfunction

   task automatic cordic_sin_cos(input longint ang, output longint sn, output longint cs);
      longint x, y, t, a;
      bit flip;
      x = GAIN_Q;
      y = 0;
      flip = 0;
      a = ang % TWO_PI_Q;
      if (a > PI_Q) a -= TWO_PI_Q;
      if (a < -PI_Q) a += TWO_PI_Q;
      if (a > HALF_PI_Q) begin
         a -= PI_Q;
         flip = 1;
      end else if (a < -HALF_PI_Q) begin
         a += PI_Q;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
         if (a >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            x = t;
            a -= ATAN_Q[i];
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            x = t;
            a += ATAN_Q[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      sn = round_shift(y, TF - WF);
      cs = round_shift(x, TF - WF);
   endtask

   task automatic predict_jacobian(input angles_type q);
      longint rot [3][3];
      longint pos [3];
      longint axis [JOINTS][3];
      longint org [JOINTS][3];
      longint d [3];
      longint lin [3];
      longint sn, cs, acc, cu, cv;
      int a, u, v;
      column_type col;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) rot[r][c] = (r == c) ? (64'sd1 <<< WF) : 0;
         pos[r] = BASE_Q[r];
      end
      for (int k = 0; k < JOINTS; k++) begin
         a = JOINT_AXIS[k];
         u = (a + 1) % 3;
         v = (a + 2) % 3;
         cordic_sin_cos(longint'(q[k]) <<< (TF - ANGLE_FRAC_BITS), sn, cs);
         for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) acc += rot[r][c] * LINK_Q[k][c];
            pos[r] += round_shift(acc, WF);
         end
         for (int r = 0; r < 3; r++) begin
            cu = rot[r][u];
            cv = rot[r][v];
            rot[r][u] = round_shift(cs * cu + sn * cv, WF);
            rot[r][v] = round_shift(cs * cv - sn * cu, WF);
         end
         for (int r = 0; r < 3; r++) begin
            axis[k][r] = rot[r][a];
            org[k][r] = pos[r];
         end
      end
      for (int r = 0; r < 3; r++) begin
         acc = 0;
         for (int c = 0; c < 3; c++) acc += rot[r][c] * TOOL_Q[c];
         pos[r] += round_shift(acc, WF);
      end
      for (int k = 0; k < JOINTS; k++) begin
         for (int r = 0; r < 3; r++) d[r] = pos[r] - org[k][r];
         lin[0] = round_shift(axis[k][1] * d[2] - axis[k][2] * d[1], WF);
         lin[1] = round_shift(axis[k][2] * d[0] - axis[k][0] * d[2], WF);
         lin[2] = round_shift(axis[k][0] * d[1] - axis[k][1] * d[0], WF);
         col.column_index = COL_W'(k);
         col.linear_x = to_output(lin[0]);
         col.linear_y = to_output(lin[1]);
         col.linear_z = to_output(lin[2]);
         col.axis_x = to_output(axis[k][0]);
         col.axis_y = to_output(axis[k][1]);
         col.axis_z = to_output(axis[k][2]);
         col.tip_x = to_output(pos[0]);
         col.tip_y = to_output(pos[1]);
         col.tip_z = to_output(pos[2]);
         col.last_column = (k == JOINTS - 1);
         expected_columns.push_back(col);
      end
   endtask

   task automatic send_request(input angles_type q);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.joint1_angle <= q[0];
      req.joint2_angle <= q[1];
      req.joint3_angle <= q[2];
      req.joint4_angle <= q[3];
      req.joint5_angle <= q[4];
      req.joint6_angle <= q[5];
      predict_jacobian(q);
      do @(posedge clock); while (!req.ready);
      requests_sent++;
   endtask

   // response side: random back-pressure, in-order comparison
   initial begin
      int stall;
      column_type want;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 5);
         if (stall != 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         columns_seen++;
         if (expected_columns.size() == 0) begin
            $error("unexpected column %0d", rsp.column_index);
            errors++;
         end else begin
            want = expected_columns.pop_front();
            if (rsp.column_index !== want.column_index) begin
               $error("column_index expected %0d actual %0d", want.column_index,
                      rsp.column_index);
               errors++;
            end
            if (rsp.linear_x !== want.linear_x) begin
               $error("linear_x expected %0d actual %0d", want.linear_x, rsp.linear_x);
               errors++;
            end
            if (rsp.linear_y !== want.linear_y) begin
               $error("linear_y expected %0d actual %0d", want.linear_y, rsp.linear_y);
               errors++;
            end
            if (rsp.linear_z !== want.linear_z) begin
               $error("linear_z expected %0d actual %0d", want.linear_z, rsp.linear_z);
               errors++;
            end
            if (rsp.axis_x !== want.axis_x) begin
               $error("axis_x expected %0d actual %0d", want.axis_x, rsp.axis_x);
               errors++;
            end
            if (rsp.axis_y !== want.axis_y) begin
               $error("axis_y expected %0d actual %0d", want.axis_y, rsp.axis_y);
               errors++;
            end
            if (rsp.axis_z !== want.axis_z) begin
               $error("axis_z expected %0d actual %0d", want.axis_z, rsp.axis_z);
               errors++;
            end
            if (rsp.tip_x !== want.tip_x) begin
               $error("tip_x expected %0d actual %0d", want.tip_x, rsp.tip_x);
               errors++;
            end
            if (rsp.tip_y !== want.tip_y) begin
               $error("tip_y expected %0d actual %0d", want.tip_y, rsp.tip_y);
               errors++;
            end
            if (rsp.tip_z !== want.tip_z) begin
               $error("tip_z expected %0d actual %0d", want.tip_z, rsp.tip_z);
               errors++;
            end
            if (rsp.last_column !== want.last_column) begin
               $error("last_column expected %0d actual %0d", want.last_column,
                      rsp.last_column);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            idle_cycles = 0;
         end else if (!reset) begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d columns outstanding", expected_columns.size());
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   task automatic test_directed_extremes();
      angles_type q;
      angle_type picks [10] = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sd6434, -16'sd6434,
                                16'sd12868, -16'sd12868, 16'sd25736, 16'sd1, -16'sd1};
      for (int n = 0; n < 10; n++) begin
         for (int j = 0; j < JOINTS; j++) q[j] = picks[n];
         send_request(q);
      end
      // each joint alone, even ones at a quarter turn and odd ones at a half turn, the others at zero
      for (int j = 0; j < JOINTS; j++) begin
         for (int m = 0; m < JOINTS; m++) q[m] = '0;
         q[j] = (j % 2 == 0) ? 16'sd6434 : 16'sd12868;
         send_request(q);
      end
      // just either side of the quarter turn where the range fold happens
      for (int m = 0; m < JOINTS; m++) q[m] = (m % 2 == 0) ? 16'sd6433 : 16'sd6435;
      send_request(q);
      for (int m = 0; m < JOINTS; m++) q[m] = (m % 2 == 0) ? -16'sd6435 : -16'sd6433;
      send_request(q);
      for (int m = 0; m < JOINTS; m++) q[m] = (m % 2 == 0) ? 16'sh5555 : -16'sh5556;
      send_request(q);
   endtask

   task automatic test_random_poses();
      angles_type q;
      for (int n = 0; n < 291; n++) begin
         for (int j = 0; j < JOINTS; j++) begin
            if (n % 3 == 0) begin
               q[j] = angle_type'($urandom_range(0, 16'hFFFF));
            end else begin
               // mostly within one turn, where a real arm lives
               q[j] = angle_type'(int'($urandom_range(0, 25736)) - 12868);
            end
         end
         send_request(q);
      end
   endtask

   task automatic wait_for_drain();
      while (expected_columns.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      errors = 0;
      requests_sent = 0;
      columns_seen = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.joint1_angle = '0;
      req.joint2_angle = '0;
      req.joint3_angle = '0;
      req.joint4_angle = '0;
      req.joint5_angle = '0;
      req.joint6_angle = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_random_poses();
      req.valid <= 1'b0;
      wait_for_drain();
      $display("covered %0d requests and %0d jacobian columns", requests_sent, columns_seen);
      $display("angles at extremes, fold boundaries, single joints and random poses");
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
